[rtl/core/metaball_field_palette_shader_assert.svh]
// Assertion macros for the metaball shader RTL.
// Included by modules that carry concurrent checks; depends on clk and rst_n in scope.
`ifndef METABALL_FIELD_PALETTE_SHADER_ASSERT_SVH
`define METABALL_FIELD_PALETTE_SHADER_ASSERT_SVH
`ifndef SYNTHESIS
`define MFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFPS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MFPS_ASSERT(lbl, prop, msg)
`define MFPS_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/core/mfps_pkg.sv]
// Shared types, constants and palette table for the metaball shader.
// No dependencies; used by every module of the block.
package mfps_pkg;

  localparam int MAX_BALLS     = 6;
  localparam int BALL_COUNT    = 6;
  localparam int PALETTE_COUNT = 4;

  localparam int COORD_W = 6;
  localparam int BALL_W  = 48;
  localparam int DX_W    = 17;
  localparam int SQ_W    = 32;
  localparam int D2_W    = 33;
  localparam int R2_W    = 16;
  localparam int TERM_W  = 21;
  localparam int SUM_W   = 22;
  localparam int VAL_W   = 11;
  localparam int OFF_W   = 9;
  localparam int NUM_W   = 17;
  localparam int RCP_W   = 18;
  localparam int RCP_SH  = 26;

  localparam int DIV_STAGES  = TERM_W;
  localparam int DIST_STAGES = 3;
  localparam int SHADE_STAGES = 7;
  localparam int LATENCY = DIST_STAGES + DIV_STAGES + SHADE_STAGES;

  localparam logic [D2_W-1:0]  D2_FLOOR   = D2_W'(104858);
  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] VAL_OFFSET = SUM_W'(307);
  localparam logic [VAL_W-1:0] VAL_ONE    = VAL_W'(1024);
  localparam logic [VAL_W-1:0] BREAK_A    = VAL_W'(338);
  localparam logic [VAL_W-1:0] BREAK_B    = VAL_W'(676);
  localparam int SPAN_A = 338;
  localparam int SPAN_B = 338;
  localparam int SPAN_C = 348;
  localparam logic [RCP_W-1:0] RCP_A = RCP_W'(((1 << RCP_SH) + SPAN_A - 1) / SPAN_A);
  localparam logic [RCP_W-1:0] RCP_B = RCP_W'(((1 << RCP_SH) + SPAN_B - 1) / SPAN_B);
  localparam logic [RCP_W-1:0] RCP_C = RCP_W'(((1 << RCP_SH) + SPAN_C - 1) / SPAN_C);

  // Register map
  localparam logic [2:0] REG_PALETTE = 3'd6;

  typedef enum logic [1:0] {
    SEG_A = 2'd0,
    SEG_B = 2'd1,
    SEG_C = 2'd2
  } seg_t;

  typedef struct packed {
    logic [D2_W-1:0] d2;
    logic [R2_W-1:0] r2;
  } ball_dist_t;

  // Palette table indexed {palette, stop, channel}; channel 3 unused
  localparam logic [7:0] PAL_ROM [64] = '{
    8'd20,  8'd0,   8'd5,   8'd0,  8'd180, 8'd20,  8'd0,   8'd0,
    8'd255, 8'd120, 8'd0,   8'd0,  8'd255, 8'd240, 8'd80,  8'd0,
    8'd5,   8'd0,   8'd30,  8'd0,  8'd0,   8'd40,  8'd180, 8'd0,
    8'd0,   8'd140, 8'd255, 8'd0,  8'd180, 8'd230, 8'd255, 8'd0,
    8'd0,   8'd15,  8'd5,   8'd0,  8'd0,   8'd120, 8'd20,  8'd0,
    8'd80,  8'd220, 8'd0,   8'd0,  8'd200, 8'd255, 8'd100, 8'd0,
    8'd15,  8'd0,   8'd25,  8'd0,  8'd120, 8'd0,   8'd160, 8'd0,
    8'd255, 8'd50,  8'd150, 8'd0,  8'd255, 8'd180, 8'd255, 8'd0
  };

  function automatic logic [7:0] pal_chan(input logic [1:0] pal, input logic [1:0] stop,
                                          input logic [1:0] ch);
    return PAL_ROM[{pal, stop, ch}];
  endfunction

  // Wrap a palette code into the populated range by repeated subtraction
  function automatic logic [1:0] pal_wrap(input logic [1:0] sel, input int count);
    logic [2:0] v;
    logic [2:0] c;
    v = {1'b0, sel};
    c = 3'(count);
    for (int i = 0; i < 3; i++) begin
      if (v >= c) v = v - c;
    end
    return v[1:0];
  endfunction

endpackage

[rtl/core/mfps_dist.sv]
// Squared distance from pixel to one ball, three register stages.
// Depends on mfps_pkg.
module mfps_dist (
  input  logic                            clk,
  input  logic                            en,
  input  logic [mfps_pkg::COORD_W-1:0]    px,
  input  logic [mfps_pkg::COORD_W-1:0]    py,
  input  logic [mfps_pkg::BALL_W-1:0]     ball,
  output mfps_pkg::ball_dist_t            bd
);

  logic signed [mfps_pkg::DX_W-1:0] dx_r, dy_r;
  logic [mfps_pkg::R2_W-1:0]        r2_a_r, r2_b_r, r2_c_r;
  logic [mfps_pkg::SQ_W-1:0]        sx_r, sy_r;
  logic [mfps_pkg::D2_W-1:0]        d2_r;
  logic signed [2*mfps_pkg::DX_W-1:0] sqx, sqy;
  logic [mfps_pkg::D2_W-1:0]        d2_sum;

  assign sqx    = dx_r * dx_r;
  assign sqy    = dy_r * dy_r;
  assign d2_sum = {1'b0, sx_r} + {1'b0, sy_r};

  // Offsets, squares, then floored sum
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= $signed({1'b0, px, 10'b0}) - $signed({1'b0, ball[15:0]});
      dy_r   <= $signed({1'b0, py, 10'b0}) - $signed({1'b0, ball[31:16]});
      r2_a_r <= ball[47:32];
      sx_r   <= sqx[mfps_pkg::SQ_W-1:0];
      sy_r   <= sqy[mfps_pkg::SQ_W-1:0];
      r2_b_r <= r2_a_r;
      d2_r   <= (d2_sum < mfps_pkg::D2_FLOOR) ? mfps_pkg::D2_FLOOR : d2_sum;
      r2_c_r <= r2_b_r;
    end
  end

  assign bd.d2 = d2_r;
  assign bd.r2 = r2_c_r;

endmodule

[rtl/core/mfps_div.sv]
// Pipelined restoring divider: floor(r2 * 2^21 / d2), one quotient bit per stage.
// Depends on mfps_pkg.
module mfps_div (
  input  logic                           clk,
  input  logic                           en,
  input  mfps_pkg::ball_dist_t           bd,
  output logic [mfps_pkg::TERM_W-1:0]    term
);

  localparam int N = mfps_pkg::DIV_STAGES;
  localparam int W = mfps_pkg::D2_W;

  logic [W-1:0]                  rem_r [N];
  logic [W-1:0]                  dvs_r [N];
  logic [mfps_pkg::TERM_W-1:0]   q_r   [N];

  // Stage j yields quotient bit N-1-j; r2 < d2 so upper bits are zero
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [W-1:0]                rem_in, dvs_in;
    logic [mfps_pkg::TERM_W-1:0] q_in;
    logic [W:0]                  sh;
    logic                        ge;
    if (j == 0) begin : g_first
      assign rem_in = W'(bd.r2);
      assign dvs_in = bd.d2;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign dvs_in = dvs_r[j-1];
      assign q_in   = q_r[j-1];
    end
    assign sh = {rem_in, 1'b0};
    assign ge = sh >= {1'b0, dvs_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? W'(sh - {1'b0, dvs_in}) : sh[W-1:0];
        dvs_r[j] <= dvs_in;
        q_r[j]   <= {q_in[mfps_pkg::TERM_W-2:0], ge};
      end
    end
  end

  assign term = q_r[N-1];

endmodule

[rtl/core/mfps_shade.sv]
// Field sum, value mapping, gradient blend and RGB565 packing, seven stages.
// Depends on mfps_pkg.
module mfps_shade (
  input  logic                                               clk,
  input  logic                                               en,
  input  logic [mfps_pkg::MAX_BALLS-1:0][mfps_pkg::TERM_W-1:0] terms,
  input  logic [1:0]                                         pal,
  output logic [15:0]                                        pixel
);

  logic [mfps_pkg::SUM_W-1:0]  p0_r, p1_r, p2_r, sum_r;
  logic [mfps_pkg::VAL_W-1:0]  val_r;
  mfps_pkg::seg_t              seg_k_r, seg_n_r;
  logic [mfps_pkg::OFF_W-1:0]  off_r;
  logic [7:0]                  lo_r [3];
  logic [7:0]                  hi_r [3];
  logic [mfps_pkg::NUM_W-1:0]  num_r [3];
  logic [mfps_pkg::NUM_W+mfps_pkg::RCP_W-1:0] prod_r [3];
  logic [15:0]                 pixel_r;

  logic [mfps_pkg::SUM_W+1:0]  tot;
  logic [mfps_pkg::SUM_W-1:0]  vdiff;
  logic [mfps_pkg::VAL_W-1:0]  val_nxt;
  mfps_pkg::seg_t              seg_nxt;
  logic [mfps_pkg::VAL_W-1:0]  off_nxt;
  logic [8:0]                  wid;
  logic [mfps_pkg::RCP_W-1:0]  rcp;
  logic [7:0]                  ch [3];

  // Sum saturates once at the end: all terms are non-negative
  assign tot = {2'b0, p0_r} + {2'b0, p1_r} + {2'b0, p2_r};

  // Map sum to val in 0..1024
  assign vdiff = sum_r - mfps_pkg::VAL_OFFSET;
  always_comb begin
    if (sum_r <= mfps_pkg::VAL_OFFSET) val_nxt = '0;
    else if (vdiff[mfps_pkg::SUM_W-1:1] > {10'b0, mfps_pkg::VAL_ONE}) val_nxt = mfps_pkg::VAL_ONE;
    else val_nxt = vdiff[mfps_pkg::VAL_W:1];
  end

  // Pick the gradient span
  always_comb begin
    if (val_r < mfps_pkg::BREAK_A) begin
      seg_nxt = mfps_pkg::SEG_A;
      off_nxt = val_r;
    end else if (val_r < mfps_pkg::BREAK_B) begin
      seg_nxt = mfps_pkg::SEG_B;
      off_nxt = val_r - mfps_pkg::BREAK_A;
    end else begin
      seg_nxt = mfps_pkg::SEG_C;
      off_nxt = val_r - mfps_pkg::BREAK_B;
    end
  end

  always_comb begin
    case (seg_k_r)
      mfps_pkg::SEG_A: wid = 9'(mfps_pkg::SPAN_A);
      mfps_pkg::SEG_B: wid = 9'(mfps_pkg::SPAN_B);
      default:         wid = 9'(mfps_pkg::SPAN_C);
    endcase
    case (seg_n_r)
      mfps_pkg::SEG_A: rcp = mfps_pkg::RCP_A;
      mfps_pkg::SEG_B: rcp = mfps_pkg::RCP_B;
      default:         rcp = mfps_pkg::RCP_C;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= {1'b0, terms[0]} + {1'b0, terms[1]};
      p1_r    <= {1'b0, terms[2]} + {1'b0, terms[3]};
      p2_r    <= {1'b0, terms[4]} + {1'b0, terms[5]};
      sum_r   <= (tot > {2'b0, mfps_pkg::SUM_MAX}) ? mfps_pkg::SUM_MAX
                                                    : tot[mfps_pkg::SUM_W-1:0];
      val_r   <= val_nxt;
      seg_k_r <= seg_nxt;
      off_r   <= off_nxt[mfps_pkg::OFF_W-1:0];
      seg_n_r <= seg_k_r;
      pixel_r <= {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
    end
  end

  // Per channel: stop lookup, blend numerator, reciprocal multiply
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic signed [8:0]  diff;
    logic signed [18:0] part;
    logic [16:0]        base;
    logic signed [18:0] num;
    assign diff = $signed({1'b0, hi_r[c]}) - $signed({1'b0, lo_r[c]});
    assign part = diff * $signed({1'b0, off_r});
    assign base = lo_r[c] * wid;
    assign num  = $signed({2'b0, base}) + part;
    assign ch[c] = prod_r[c][mfps_pkg::RCP_SH +: 8];
    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[c]   <= mfps_pkg::pal_chan(pal, seg_nxt, 2'(c));
        hi_r[c]   <= mfps_pkg::pal_chan(pal, 2'(seg_nxt) + 2'd1, 2'(c));
        num_r[c]  <= num[mfps_pkg::NUM_W-1:0];
        prod_r[c] <= num_r[c] * rcp;
      end
    end
  end

  assign pixel = pixel_r;

endmodule

[rtl/core/metaball_field_palette_shader.sv]
// Metaball field palette shader: per-pixel metaball field coloured through a gradient.
// Usage:
//   Input channel in_valid/in_ready carries one grid pixel (in_grid_x, in_grid_y).
//   Result channel out_valid/out_ready returns out_pixel_color (RGB565) with the
//   pixel coordinates echoed in out_x and out_y, in input order.
//   Configuration is an APB-style port, 64-bit data, register i at byte 8*i:
//   ball_params_0..5 then palette_select; writes complete in the access cycle,
//   pready is tied high. Write configuration only while the block is empty.
// From accept to out_valid the pipeline has 3 distance stages, a 21-stage
// restoring divider (one quotient bit per stage, one per ball), and 7 stages for
// summing, value mapping, gradient blend and packing.
// Throughput is one item per cycle; a new item enters every cycle while the
// receiver takes results.
// A synchronous active-low reset empties the pipeline and clears the configuration registers.
// When the receiver stalls with a result held, the whole pipeline freezes and
// in_ready drops; nothing is lost or repeated.
`include "metaball_field_palette_shader_assert.svh"
module metaball_field_palette_shader #(
  parameter int BALL_COUNT    = mfps_pkg::BALL_COUNT,
  parameter int PALETTE_COUNT = mfps_pkg::PALETTE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mfps_pkg::COORD_W-1:0]  in_grid_x,
  input  logic [mfps_pkg::COORD_W-1:0]  in_grid_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_pixel_color,
  output logic [mfps_pkg::COORD_W-1:0]  out_x,
  output logic [mfps_pkg::COORD_W-1:0]  out_y,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [5:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  localparam int LAT = mfps_pkg::LATENCY;

  logic [mfps_pkg::BALL_W-1:0] ball_r [mfps_pkg::MAX_BALLS];
  logic [1:0]                  pal_sel_r;
  logic [LAT-1:0]              vld_r, vld_nxt;
  logic [2*mfps_pkg::COORD_W-1:0] xy_r [LAT];
  logic                        adv;
  logic                        wr_en;
  logic [2:0]                  wr_idx;
  logic [mfps_pkg::MAX_BALLS-1:0][mfps_pkg::TERM_W-1:0] terms;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = paddr[5:3];

  // Register writes; index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mfps_pkg::MAX_BALLS; i++) ball_r[i] <= '0;
      pal_sel_r <= '0;
    end else if (wr_en) begin
      if (wr_idx < 3'(mfps_pkg::MAX_BALLS)) ball_r[wr_idx] <= pwdata[mfps_pkg::BALL_W-1:0];
      else if (wr_idx == mfps_pkg::REG_PALETTE) pal_sel_r <= pwdata[1:0];
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    if (wr_idx < 3'(mfps_pkg::MAX_BALLS)) prdata = {16'b0, ball_r[wr_idx]};
    else if (wr_idx == mfps_pkg::REG_PALETTE) prdata = {62'b0, pal_sel_r};
  end

  // Advance the pipeline unless a held result is stalled
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  // Carry coordinates alongside the datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      xy_r[0] <= {in_grid_y, in_grid_x};
      for (int i = 1; i < LAT; i++) xy_r[i] <= xy_r[i-1];
    end
  end

  // One distance and divider lane per populated ball
  for (genvar b = 0; b < mfps_pkg::MAX_BALLS; b++) begin : g_ball
    if (b < BALL_COUNT) begin : g_on
      mfps_pkg::ball_dist_t bd;
      mfps_dist u_dist (
        .clk (clk), .en (adv), .px (in_grid_x), .py (in_grid_y),
        .ball (ball_r[b]), .bd (bd)
      );
      mfps_div u_div (.clk (clk), .en (adv), .bd (bd), .term (terms[b]));
    end else begin : g_off
      assign terms[b] = '0;
    end
  end

  mfps_shade u_shade (
    .clk   (clk),
    .en    (adv),
    .terms (terms),
    .pal   (mfps_pkg::pal_wrap(pal_sel_r, PALETTE_COUNT)),
    .pixel (out_pixel_color)
  );

  assign out_valid = vld_r[LAT-1];
  assign out_x     = xy_r[LAT-1][mfps_pkg::COORD_W-1:0];
  assign out_y     = xy_r[LAT-1][2*mfps_pkg::COORD_W-1:mfps_pkg::COORD_W];

  `MFPS_ASSERT(a_stall_freezes, !adv |=> $stable(vld_r) && $stable(out_pixel_color), "pipeline moved during stall")
  `MFPS_ASSERT(a_accept_enters, in_valid && in_ready |=> vld_r[0], "accepted item not in first stage")
  `MFPS_ASSERT(a_drain_empties, out_valid && out_ready && !vld_r[LAT-2] |=> !out_valid, "result repeated")

endmodule

[bench/shader_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the metaball palette shader: mirrors the register writes,
// predicts each pixel colour and compares the result items in order. Needs mfps_pkg.
module shader_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [5:0]  in_grid_x,
  input  logic [5:0]  in_grid_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_pixel_color,
  input  logic [5:0]  out_x,
  input  logic [5:0]  out_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          mismatches,
  output int          pixels_waiting,
  output int          pixels_seen
);

  typedef struct {
    logic [15:0] colour;
    logic [5:0]  x;
    logic [5:0]  y;
  } pixel_t;

  localparam int D2_MIN  = 104858;
  localparam int SUM_TOP = 4194303;
  localparam int OFFSET  = 307;
  localparam int ONE     = 1024;

  localparam int GRADIENT [4][4][3] = '{
    '{'{20, 0, 5},   '{180, 20, 0},  '{255, 120, 0},  '{255, 240, 80}},
    '{'{5, 0, 30},   '{0, 40, 180},  '{0, 140, 255},  '{180, 230, 255}},
    '{'{0, 15, 5},   '{0, 120, 20},  '{80, 220, 0},   '{200, 255, 100}},
    '{'{15, 0, 25},  '{120, 0, 160}, '{255, 50, 150}, '{255, 180, 255}}
  };

  logic [47:0] ball_regs [mfps_pkg::MAX_BALLS];
  logic [1:0]  palette_reg;
  pixel_t      pixel_q [$];

  // Sum the field of all balls, map it through the gradient, pack as RGB565
  function automatic logic [15:0] field_colour(input logic [5:0] gx, input logic [5:0] gy);
    longint dx, dy, d2, field;
    int val, off, w, pal, lo, hi;
    int chan [3];
    mfps_pkg::seg_t seg;
    field = 0;
    for (int i = 0; i < mfps_pkg::BALL_COUNT; i++) begin
      dx = longint'(gx) * 1024 - longint'(ball_regs[i][15:0]);
      dy = longint'(gy) * 1024 - longint'(ball_regs[i][31:16]);
      d2 = dx * dx + dy * dy;
      if (d2 < D2_MIN) d2 = D2_MIN;
      field = field + (longint'(ball_regs[i][47:32]) << 21) / d2;
      if (field > SUM_TOP) field = SUM_TOP;
    end
    val = (field <= OFFSET) ? 0 : int'((field - OFFSET) >> 1);
    if (val > ONE) val = ONE;
    if (val < 338) begin
      seg = mfps_pkg::SEG_A; off = val; w = mfps_pkg::SPAN_A;
    end else if (val < 676) begin
      seg = mfps_pkg::SEG_B; off = val - 338; w = mfps_pkg::SPAN_B;
    end else begin
      seg = mfps_pkg::SEG_C; off = val - 676; w = mfps_pkg::SPAN_C;
    end
    pal = int'(palette_reg) % mfps_pkg::PALETTE_COUNT;
    for (int c = 0; c < 3; c++) begin
      lo = GRADIENT[pal][int'(seg)][c];
      hi = GRADIENT[pal][int'(seg) + 1][c];
      chan[c] = (lo * w + (hi - lo) * off) / w;
      if (chan[c] < 0) chan[c] = 0;
      chan[c] = chan[c] & 8'hFF;
    end
    return {chan[0][7:3], chan[1][7:2], chan[2][7:3]};
  endfunction

  assign pixels_waiting = pixel_q.size();

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      foreach (ball_regs[i]) ball_regs[i] <= '0;
      palette_reg <= '0;
      mismatches  <= 0;
      pixels_seen <= 0;
      pixel_q.delete();
    end else begin
      // mirror register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[5:3] < mfps_pkg::MAX_BALLS) ball_regs[paddr[5:3]] <= pwdata[47:0];
        else if (paddr[5:3] == mfps_pkg::REG_PALETTE) palette_reg <= pwdata[1:0];
      end
      // predict each accepted item
      if (in_valid && in_ready)
        pixel_q.push_back('{field_colour(in_grid_x, in_grid_y), in_grid_x, in_grid_y});
      // compare each delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        pixels_seen <= pixels_seen + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result colour %h x %0d y %0d",
                   $time, out_pixel_color, out_x, out_y);
          mismatches <= mismatches + 1;
        end else begin
          want = pixel_q.pop_front();
          if (want.colour !== out_pixel_color || want.x !== out_x || want.y !== out_y) begin
            $display("%0t: mismatch expected colour %h x %0d y %0d, got colour %h x %0d y %0d",
                     $time, want.colour, want.x, want.y, out_pixel_color, out_x, out_y);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the shader bench: clock, reset, register programming, pixel stimulus
// and verdict. Needs mfps_pkg, the shader RTL and shader_scoreboard.
module testbench;

  localparam int REG_UNMAPPED = 7;
  localparam int PIPE_DEPTH   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [5:0]  in_grid_x = '0;
  logic [5:0]  in_grid_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pixel_color;
  logic [5:0]  out_x, out_y;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int mismatches, pixels_waiting, pixels_seen;
  int send_idle = 0, take_idle = 0;
  bit hold_request = 1'b0;
  int items_sent = 0;

  metaball_field_palette_shader DUT (.*);

  shader_scoreboard u_scoreboard (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout guard
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_request = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= take_idle);
    end
  end

  task automatic reg_write(input int idx, input logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx * 8); pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Hold until every predicted pixel has come back, then let the pipe empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_waiting != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  task automatic send_pixel(input logic [5:0] gx, input logic [5:0] gy);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_grid_x <= gx; in_grid_y <= gy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [63:0] random_ball(input bit wide);
    logic [15:0] bx, by, r2;
    bx = wide ? 16'($urandom) : 16'($urandom_range(0, 48 * 1024));
    by = wide ? 16'($urandom) : 16'($urandom_range(0, 48 * 1024));
    case ($urandom_range(3))
      0:       r2 = 16'($urandom);
      1:       r2 = 16'($urandom_range(0, 64));
      default: r2 = 16'($urandom_range(0, 4096));
    endcase
    return {16'($urandom), r2, by, bx};
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all balls cleared: the field is empty everywhere
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    send_pixel(6'd47, 6'd0);
    drain();

    // largest radius at the origin, a ball at the far corner, unmapped write ignored
    reg_write(0, 64'hFFFF_0000_0000);
    reg_write(1, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(2, {16'h0, 16'h0100, 16'(20 * 1024), 16'(20 * 1024)});
    reg_write(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int p = 0; p < 4; p++) begin
      reg_write(mfps_pkg::REG_PALETTE, 64'(p));
      send_pixel(6'd0, 6'd0);
      send_pixel(6'd20, 6'd20);
      send_pixel(6'd21, 6'd20);
      send_pixel(6'd30, 6'd30);
      send_pixel(6'd63, 6'd0);
      drain();
    end

    // random phases, each with its own ball set, cycling through the palettes
    for (int phase = 0; phase < 9; phase++) begin
      send_idle = (phase < 3) ? 14 : (phase < 6) ? 88 : 0;
      take_idle = (phase < 3) ? 88 : (phase < 6) ? 14 : 0;
      for (int b = 0; b < mfps_pkg::MAX_BALLS; b++)
        reg_write(b, (phase == 8) ? 64'hFFFF_FFFF_FFFF : random_ball(phase == 4));
      reg_write(mfps_pkg::REG_PALETTE, {$urandom, 30'h0, 2'(phase)});
      for (int n = 0; n < 210; n++) begin
        if (phase == 7 && n == 20) hold_request = 1'b1;
        if (phase == 6 && n == 100) drain();
        if ($urandom_range(9) == 0)
          send_pixel(6'($urandom), 6'($urandom));
        else
          send_pixel(6'($urandom_range(0, 47)), 6'($urandom_range(0, 47)));
      end
      drain();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_waiting != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    $display("Covered %0d pixels over eleven ball sets, all four palettes and both", items_sent);
    $display("stall patterns; %0d colours checked.", pixels_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mfps_pkg.sv
rtl/core/mfps_dist.sv
rtl/core/mfps_div.sv
rtl/core/mfps_shade.sv
rtl/core/metaball_field_palette_shader.sv
bench/shader_scoreboard.sv
bench/testbench.sv
